// ----- sv/avde_pkg.sv -----
// ----------------------------------------------------------------------------
// avde_pkg
// Shared types, constants and the segment encoder for the voltmeter display
// encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package avde_pkg;

    localparam int SAMPLE_W = 10;
    localparam int MV_W     = 12;
    localparam int BAR_W    = 3;
    localparam int DIGIT_W  = 4;
    localparam int SEG_W    = 8;
    localparam int REM1K_W  = 10;
    localparam int REM100_W = 7;

    // mv = floor(sample * 244 / 100) = (sample * SCALE_MULT) >> SCALE_SHIFT
    // SCALE_MULT = 61 * ceil(2^21 / 25); the excess stays below 0.03 over the
    // whole sample range, under the 1/25 margin of the exact quotient.
    localparam int SCALE_MULT_W = 23;
    localparam int PROD_W       = SAMPLE_W + SCALE_MULT_W;
    localparam int SCALE_SHIFT  = 21;
    localparam logic [SCALE_MULT_W-1:0] SCALE_MULT = 23'd5117107;

    localparam logic [MV_W-1:0] MV_MAX = 12'd2496;

    localparam int NUM_BARS = 6;
    localparam logic [BAR_W-1:0] BAR_NONE = 3'd6;
    localparam logic [MV_W-1:0] BAR_LIMITS [NUM_BARS] = '{
        12'd417, 12'd834, 12'd1251, 12'd1668, 12'd2085, 12'd2501
    };

    localparam int OUT_DATA_W = 48;

    typedef logic [MV_W-1:0]    mv_t;
    typedef logic [BAR_W-1:0]   bar_t;
    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [SEG_W-1:0]   seg_t;

    // Upper split of the millivolt value: bar, thousands, hundreds, rest
    typedef struct packed {
        bar_t                  bar;
        digit_t                thou;
        digit_t                hund;
        logic [REM100_W-1:0]   rem;
    } hi_split_t;

    typedef struct packed {
        seg_t thou;
        seg_t hund;
        seg_t tens;
        seg_t units;
    } seg_set_t;

    // Active-low pattern, bit 7 decimal point (off), bits 6..0 segments g..a
    function automatic seg_t seg_encode(input digit_t d);
        seg_t s;
        case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = 8'hFF;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- sv/avde_scale.sv -----
// ----------------------------------------------------------------------------
// avde_scale
// Scales a converter sample to millivolts by a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module avde_scale
    import avde_pkg::*;
(
    input  wire logic [SAMPLE_W-1:0] sample,
    output mv_t                      mv
);

    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(sample) * PROD_W'(SCALE_MULT);
    assign mv   = prod[SCALE_SHIFT +: MV_W];

endmodule

`default_nettype wire

// ----- sv/avde_split_hi.sv -----
// ----------------------------------------------------------------------------
// avde_split_hi
// Bar level, thousands and hundreds digits of the millivolt value.
// ----------------------------------------------------------------------------
`default_nettype none

module avde_split_hi
    import avde_pkg::*;
(
    input  mv_t       mv,
    output hi_split_t split
);

    logic [REM1K_W-1:0] rem1k;
    digit_t             thou;
    digit_t             hund;
    logic [REM1K_W-1:0] hund_base;
    bar_t               bar;

    always_comb
    begin
        bar = BAR_NONE;
        for (int i = NUM_BARS - 1; i >= 0; i--)
        begin
            if (mv < BAR_LIMITS[i])
            begin
                bar = BAR_W'(i);
            end
        end
    end

    always_comb
    begin
        if (mv >= 12'd2000)
        begin
            thou  = 4'd2;
            rem1k = REM1K_W'(mv - 12'd2000);
        end
        else if (mv >= 12'd1000)
        begin
            thou  = 4'd1;
            rem1k = REM1K_W'(mv - 12'd1000);
        end
        else
        begin
            thou  = 4'd0;
            rem1k = REM1K_W'(mv);
        end
    end

    // Independent compares against each hundred; the highest match wins
    always_comb
    begin
        hund      = '0;
        hund_base = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem1k >= REM1K_W'(k * 100))
            begin
                hund      = DIGIT_W'(k);
                hund_base = REM1K_W'(k * 100);
            end
        end
    end

    assign split.bar  = bar;
    assign split.thou = thou;
    assign split.hund = hund;
    assign split.rem  = REM100_W'(rem1k - hund_base);

endmodule

`default_nettype wire

// ----- sv/avde_split_lo.sv -----
// ----------------------------------------------------------------------------
// avde_split_lo
// Tens and units digits, and segment patterns of all four digits.
// ----------------------------------------------------------------------------
`default_nettype none

module avde_split_lo
    import avde_pkg::*;
(
    input  hi_split_t split,
    output seg_set_t  segs
);

    digit_t              tens;
    logic [REM100_W-1:0] tens_base;
    digit_t              units;

    always_comb
    begin
        tens      = '0;
        tens_base = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (split.rem >= REM100_W'(k * 10))
            begin
                tens      = DIGIT_W'(k);
                tens_base = REM100_W'(k * 10);
            end
        end
    end

    assign units = DIGIT_W'(split.rem - tens_base);

    assign segs.thou  = seg_encode(split.thou);
    assign segs.hund  = seg_encode(split.hund);
    assign segs.tens  = seg_encode(tens);
    assign segs.units = seg_encode(units);

endmodule

`default_nettype wire

// ----- sv/adc_voltmeter_display_encoder_unit.sv -----
// Throughput: one sample per cycle unless m_axis_tready stalls the output;
// four register stages (input, millivolts, upper digit split, result), each
// of which moves whenever the next has room.
// Reset clears all valid flags; data registers are not reset.
// ----------------------------------------------------------------------------
// adc_voltmeter_display_encoder_unit
// Converts 10-bit samples to millivolts, bar level and four seven-segment
// digit patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_voltmeter_display_encoder_unit
    import avde_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,  // [9:0] sample
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [11:0] millivolts, [14:12] bar_level, [22:15] seg_thousands,
    // [30:23] seg_hundreds, [38:31] seg_tens, [46:39] seg_units
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    logic [SAMPLE_W-1:0] sample_reg;
    logic                v0_reg;
    mv_t                 mv_reg;
    logic                v1_reg;
    mv_t                 mv2_reg;
    hi_split_t           hi_reg;
    logic                v2_reg;
    mv_t                 mv3_reg;
    bar_t                bar3_reg;
    seg_set_t            seg_reg;
    logic                v3_reg;

    logic rdy0, rdy1, rdy2, rdy3;

    mv_t       mv_next;
    hi_split_t hi_next;
    seg_set_t  seg_next;

    // A stage takes new data when it is empty or its content moves on
    assign rdy3 = !v3_reg || m_axis_tready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;

    assign s_axis_tready = rdy0;

    avde_scale u_scale (
        .sample (sample_reg),
        .mv     (mv_next)
    );

    avde_split_hi u_split_hi (
        .mv    (mv_reg),
        .split (hi_next)
    );

    avde_split_lo u_split_lo (
        .split (hi_reg),
        .segs  (seg_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
            begin
                v0_reg <= s_axis_tvalid;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && s_axis_tvalid)
        begin
            sample_reg <= s_axis_tdata[SAMPLE_W-1:0];
        end
        if (rdy1 && v0_reg)
        begin
            mv_reg <= mv_next;
        end
        if (rdy2 && v1_reg)
        begin
            mv2_reg <= mv_reg;
            hi_reg  <= hi_next;
        end
        if (rdy3 && v2_reg)
        begin
            mv3_reg  <= mv2_reg;
            bar3_reg <= hi_reg.bar;
            seg_reg  <= seg_next;
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {1'b0, seg_reg.units, seg_reg.tens, seg_reg.hund,
                            seg_reg.thou, bar3_reg, mv3_reg};

    // Scaled value never exceeds full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> mv_reg <= MV_MAX)
        else $error("millivolt value above full scale");

    // Upper split leaves proper digits and a remainder below one hundred
    assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (hi_reg.rem < 7'd100) && (hi_reg.hund <= 4'd9)
                   && (hi_reg.thou <= 4'd2))
        else $error("digit split out of range");

    // No-bar level cannot appear within the 10-bit range
    assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> bar3_reg != BAR_NONE)
        else $error("bar level beyond full scale");

    // Accepted sample always lands in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v0_reg)
        else $error("accepted sample lost at input stage");

    // A stalled stage keeps its item
    assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !rdy2) |=> v2_reg && $stable(hi_reg))
        else $error("stalled split stage changed");

endmodule

`default_nettype wire
